// ----- hw/rtl/lca_pkg.sv -----
// Shared types and constants for the Life automaton block.
// Used by lca_row_cell, lca_gen_row and life_cellular_automaton; no dependencies.
package lca_pkg;

	typedef enum logic [1:0] {
		CMD_TOGGLE = 2'd0,
		CMD_STEP   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_e;

	typedef struct packed {
		cmd_e       cmd;
		logic [5:0] col;
		logic [5:0] row;
	} req_t;

	typedef struct packed {
		logic ok;
		logic cell_value;
	} rsp_t;

	// per-cell control: shift the ring or clear the row
	typedef struct packed {
		logic shift;
		logic clr;
	} cell_ctl_t;

	localparam logic [1:0] CFG_BOARD_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_BOARD_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_WRAP_EDGES   = 2'd2;

	localparam logic [3:0] LIFE_BIRTH   = 4'd3;
	localparam logic [3:0] LIFE_SURVIVE = 4'd2;

endpackage

// ----- hw/rtl/lca_row_cell.sv -----
// One board row held in the row ring; passes its row to the next cell on shift.
// Depends on lca_pkg (cell_ctl_t).
module lca_row_cell
	import lca_pkg::*;
#(
	parameter int unsigned COLS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_ctl_t       ctl,
	input  logic [COLS-1:0] nxt,
	output logic [COLS-1:0] row
);

	logic [COLS-1:0] row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.clr) begin
			row_q <= '0;
		end else if (ctl.shift) begin
			row_q <= nxt;
		end
	end

	assign row = row_q;

endmodule

// ----- hw/rtl/lca_gen_row.sv -----
// Next-generation rule (B3/S23) for one row from the rows above and below.
// Depends on lca_pkg (rule constants).
module lca_gen_row
	import lca_pkg::*;
#(
	parameter int unsigned COLS = 64,
	parameter int unsigned WW   = $clog2(COLS + 1)
) (
	input  logic [COLS-1:0] above,
	input  logic [COLS-1:0] cur,
	input  logic [COLS-1:0] below,
	input  logic [WW-1:0]   w_eff,
	input  logic            wrap,
	output logic [COLS-1:0] nxt
);

	localparam int unsigned CI = (COLS > 1) ? $clog2(COLS) : 1;

	logic [CI-1:0] wm1;
	logic          a_last, c_last, b_last;

	assign wm1    = CI'(w_eff - WW'(1));
	assign a_last = wrap & above[wm1];
	assign c_last = wrap & cur[wm1];
	assign b_last = wrap & below[wm1];

	for (genvar x = 0; x < COLS; x++) begin : g_col
		logic       is_last, in_w;
		logic       al, cl, bl, ar, cr, br;
		logic [3:0] n;

		assign is_last = (w_eff == WW'(x + 1));
		assign in_w    = (WW'(x) < w_eff);

		if (x == 0) begin : g_left_edge
			assign al = a_last;
			assign cl = c_last;
			assign bl = b_last;
		end else begin : g_left
			assign al = above[x-1];
			assign cl = cur[x-1];
			assign bl = below[x-1];
		end

		if (x == COLS - 1) begin : g_right_edge
			assign ar = wrap & above[0];
			assign cr = wrap & cur[0];
			assign br = wrap & below[0];
		end else begin : g_right
			assign ar = is_last ? (wrap & above[0]) : above[x+1];
			assign cr = is_last ? (wrap & cur[0])   : cur[x+1];
			assign br = is_last ? (wrap & below[0]) : below[x+1];
		end

		assign n = 4'(al) + 4'(above[x]) + 4'(ar) + 4'(cl) + 4'(cr)
			+ 4'(bl) + 4'(below[x]) + 4'(br);

		// columns beyond the active width hold their value
		assign nxt[x] = in_w ? ((n == LIFE_BIRTH) || ((n == LIFE_SURVIVE) && cur[x]))
			: cur[x];
	end

endmodule

// ----- hw/rtl/life_cellular_automaton.sv -----
// Life automaton (B3/S23) on a board held in a ring of row cells.
// Step: one ring pass of one row per cycle through two window stages (A and B),
// then row 0 is written back in S_FIX. Toggle/read: one pass of ring rotation,
// preceded in wrap mode by coordinate reduction in S_MOD. Clear: the ring clears when taken.
// The result strobe follows in the cycle after the work ends; the receiver cannot stall.
// Reset: board all dead, width and height registers 64 (clamped to MAX), wrap off. Depends on lca_pkg.
module life_cellular_automaton
	import lca_pkg::*;
#(
	parameter int unsigned MAX_COLS = 64,
	parameter int unsigned MAX_ROWS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	// command channel
	input  logic       start,
	output logic       busy,
	input  req_t       request,
	// result channel
	output logic       done,
	output rsp_t       response,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);

	localparam int unsigned WW  = $clog2(MAX_COLS + 1);
	localparam int unsigned HW  = $clog2(MAX_ROWS + 1);
	localparam int unsigned CW  = $clog2(MAX_ROWS + 2);
	localparam int unsigned CI  = $clog2(MAX_COLS);
	localparam int unsigned MWC = WW + 5;
	localparam int unsigned MWR = HW + 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_ROT,
		S_STEP,
		S_FIX
	} state_e;

	// ------------------------------------------------------------------
	// Configuration registers; writes are always taken.
	// ------------------------------------------------------------------
	logic [6:0] cfg_w_q, cfg_h_q;
	logic       wrap_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= 7'd64;
			cfg_h_q <= 7'd64;
			wrap_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BOARD_WIDTH:  cfg_w_q <= cfg_data;
				CFG_BOARD_HEIGHT: cfg_h_q <= cfg_data;
				CFG_WRAP_EDGES:   wrap_q  <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Clamp width and height: zero acts as one, large values saturate.
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	always_comb begin
		if (cfg_w_q == 7'd0) begin
			w_eff = WW'(1);
		end else if (int'(cfg_w_q) > int'(MAX_COLS)) begin
			w_eff = WW'(MAX_COLS);
		end else begin
			w_eff = WW'(cfg_w_q);
		end
		if (cfg_h_q == 7'd0) begin
			h_eff = HW'(1);
		end else if (int'(cfg_h_q) > int'(MAX_ROWS)) begin
			h_eff = HW'(MAX_ROWS);
		end else begin
			h_eff = HW'(cfg_h_q);
		end
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	state_e     state_q;
	cmd_e       cmd_q;
	logic [5:0] col_q, row_q;
	logic [2:0] k_q;
	logic [CW-1:0] cnt_q;
	logic       done_q;
	rsp_t       rsp_q;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Ring of row cells. c[0] is the head; data flows from c[i+1] to c[i],
	// the tail c[MAX_ROWS-1] takes the processed head row back.
	logic [MAX_COLS-1:0] ring [MAX_ROWS];
	logic [MAX_COLS-1:0] tail_d, head0_d;
	cell_ctl_t           ctl, ctl0;

	// Step window: A holds the row after B, P the row before B (all old values).
	logic [MAX_COLS-1:0] win_a_q, win_b_q, win_p_q;
	// Old row 0, old row 1, old last active row, saved for the deferred row 0.
	logic [MAX_COLS-1:0] old0_q, old1_q, oldl_q;

	logic [MAX_COLS-1:0] gen_above, gen_cur, gen_below, gen_nxt;

	// Step bookkeeping: B holds row y = cnt - 2.
	int   y_i;
	logic y_act, y_has_below, y_is_last;
	assign y_i         = int'(cnt_q) - 2;
	assign y_act       = (int'(cnt_q) >= 3) && (y_i < int'(h_eff));
	assign y_has_below = (y_i + 1) < int'(h_eff);
	assign y_is_last   = (int'(cnt_q) >= 2) && (y_i == int'(h_eff) - 1);

	// Toggle/read: the addressed row passes the head when cnt equals row.
	logic [CI-1:0]       col_idx;
	logic                hit;
	logic [MAX_COLS-1:0] flip_mask;
	assign col_idx   = CI'(col_q);
	assign hit       = (cnt_q == CW'(row_q));
	assign flip_mask = (cmd_q == CMD_TOGGLE) ? (MAX_COLS'(1) << col_idx) : '0;

	always_comb begin
		if (state_q == S_FIX) begin
			// row 0, deferred until the last active row was seen
			gen_above = wrap_q ? oldl_q : '0;
			gen_cur   = old0_q;
			if (h_eff == HW'(1)) begin
				gen_below = wrap_q ? old0_q : '0;
			end else begin
				gen_below = old1_q;
			end
		end else begin
			gen_above = win_p_q;
			gen_cur   = win_b_q;
			gen_below = y_has_below ? win_a_q : (wrap_q ? old0_q : '0);
		end
	end

	lca_gen_row #(
		.COLS (MAX_COLS),
		.WW   (WW)
	) u_gen (
		.above (gen_above),
		.cur   (gen_cur),
		.below (gen_below),
		.w_eff (w_eff),
		.wrap  (wrap_q),
		.nxt   (gen_nxt)
	);

	always_comb begin
		if (state_q == S_STEP) begin
			tail_d = y_act ? gen_nxt : win_b_q;
		end else begin
			tail_d = hit ? (ring[0] ^ flip_mask) : ring[0];
		end
	end

	// Clear acts on the whole ring in the cycle the command is taken.
	assign ctl.clr    = accept && (request.cmd == CMD_CLEAR);
	assign ctl.shift  = (state_q == S_ROT) || (state_q == S_STEP);
	assign ctl0.clr   = ctl.clr;
	assign ctl0.shift = ctl.shift || (state_q == S_FIX);

	if (MAX_ROWS > 1) begin : g_head_multi
		assign head0_d = (state_q == S_FIX) ? gen_nxt : ring[1];
	end else begin : g_head_single
		assign head0_d = (state_q == S_FIX) ? gen_nxt : tail_d;
	end

	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_ring
		if (i == 0) begin : g_head
			lca_row_cell #(.COLS(MAX_COLS)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl0),
				.nxt    (head0_d),
				.row    (ring[i])
			);
		end else if (i == MAX_ROWS - 1) begin : g_tail
			lca_row_cell #(.COLS(MAX_COLS)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.nxt    (tail_d),
				.row    (ring[i])
			);
		end else begin : g_mid
			lca_row_cell #(.COLS(MAX_COLS)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.nxt    (ring[i+1]),
				.row    (ring[i])
			);
		end
	end

	// Advance the step window and save the rows row 0 needs at the end.
	always_ff @(posedge clk) begin
		if (state_q == S_STEP) begin
			win_a_q <= ring[0];
			win_b_q <= win_a_q;
			win_p_q <= win_b_q;
			if (cnt_q == CW'(2)) begin
				old0_q <= win_b_q;
			end
			if (cnt_q == CW'(3)) begin
				old1_q <= win_b_q;
			end
			if (y_is_last) begin
				oldl_q <= win_b_q;
			end
		end
	end

	// Wrap mode: reduce col mod width and row mod height, one bit a cycle.
	logic [MWC-1:0] wsh;
	logic [MWR-1:0] hsh;
	logic [5:0]     col_red, row_red;
	assign wsh = MWC'(w_eff) << k_q;
	assign hsh = MWR'(h_eff) << k_q;
	assign col_red = (MWC'(col_q) >= wsh) ? (col_q - 6'(wsh)) : col_q;
	assign row_red = (MWR'(row_q) >= hsh) ? (row_q - 6'(hsh)) : row_q;

	logic out_of_range;
	assign out_of_range = (WW'(request.col) >= w_eff) || (HW'(request.row) >= h_eff)
		|| (int'(request.col) >= int'(MAX_COLS)) || (int'(request.row) >= int'(MAX_ROWS));

	// ------------------------------------------------------------------
	// Sequencer and registered result
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_TOGGLE;
			col_q   <= '0;
			row_q   <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= request.cmd;
						col_q <= request.col;
						row_q <= request.row;
						k_q   <= 3'd5;
						cnt_q <= '0;
						unique case (request.cmd)
							CMD_CLEAR: begin
								done_q <= 1'b1;
								rsp_q  <= '{ok: 1'b1, cell_value: 1'b0};
							end
							CMD_STEP: begin
								state_q <= S_STEP;
							end
							CMD_TOGGLE, CMD_READ: begin
								if (wrap_q) begin
									state_q <= S_MOD;
								end else if (out_of_range) begin
									// drop the transaction: board unchanged
									done_q <= 1'b1;
									rsp_q  <= '{ok: 1'b0, cell_value: 1'b0};
								end else begin
									state_q <= S_ROT;
								end
							end
							default: ;
						endcase
					end
				end
				S_MOD: begin
					col_q <= col_red;
					row_q <= row_red;
					k_q   <= k_q - 3'd1;
					if (k_q == 3'd0) begin
						state_q <= S_ROT;
					end
				end
				S_ROT: begin
					cnt_q <= cnt_q + CW'(1);
					if (hit) begin
						rsp_q.cell_value <= ring[0][col_idx] ^ (cmd_q == CMD_TOGGLE);
					end
					if (cnt_q == CW'(MAX_ROWS - 1)) begin
						state_q  <= S_IDLE;
						done_q   <= 1'b1;
						rsp_q.ok <= 1'b1;
					end
				end
				S_STEP: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(MAX_ROWS + 1)) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					rsp_q   <= '{ok: 1'b1, cell_value: 1'b0};
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done     = done_q;
	assign response = rsp_q;

endmodule

// ----- verif/life_cellular_automaton_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for life_cellular_automaton: drives toggle, step, clear and read
// commands, predicts each response from a shadow board, and checks every response strobe.
// Depends on lca_pkg and the life_cellular_automaton RTL.
module life_cellular_automaton_tb;
	import lca_pkg::*;

	localparam int COLS = 64;
	localparam int ROWS = 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t response;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;

	// shadow copy of the board and the configuration
	logic [COLS-1:0] shadow_board [ROWS];
	logic [6:0] shadow_width;
	logic [6:0] shadow_height;
	logic shadow_wrap;

	rsp_t expected_rsp_q [$];
	int error_count;
	int idle_cycles;
	bit allow_gaps;

	life_cellular_automaton dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.response(response),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Clamp the configured size the way the block does: zero acts as one, saturate at max.
	function automatic int active_width();
		int w;
		w = shadow_width;
		if (w == 0) w = 1;
		if (w > COLS) w = COLS;
		return w;
	endfunction

	function automatic int active_height();
		int h;
		h = shadow_height;
		if (h == 0) h = 1;
		if (h > ROWS) h = ROWS;
		return h;
	endfunction

	// Liveness of one neighbor; in wrap mode small boards may revisit the same cell.
	function automatic int neighbor_alive(int x, int y, int dx, int dy, int w, int h);
		int cx;
		int cy;
		if (shadow_wrap) begin
			cx = (x + w + dx) % w;
			cy = (y + h + dy) % h;
		end else begin
			cx = x + dx;
			cy = y + dy;
			if (cx < 0 || cy < 0 || cx >= w || cy >= h) return 0;
		end
		return shadow_board[cy][cx] ? 1 : 0;
	endfunction

	// Advance the shadow board one generation from a snapshot of the old one.
	function automatic void advance_generation();
		logic [COLS-1:0] next_board [ROWS];
		int w;
		int h;
		int n;
		w = active_width();
		h = active_height();
		next_board = shadow_board;
		for (int y = 0; y < h; y++) begin
			for (int x = 0; x < w; x++) begin
				n = 0;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++)
						if (dx != 0 || dy != 0) n += neighbor_alive(x, y, dx, dy, w, h);
				next_board[y][x] = (n == LIFE_BIRTH) ||
					(n == LIFE_SURVIVE && shadow_board[y][x]);
			end
		end
		shadow_board = next_board;
	endfunction

	// Apply one command to the shadow board and return the response it should give.
	function automatic rsp_t predict_response(req_t req);
		rsp_t rsp;
		int w;
		int h;
		int c;
		int r;
		rsp.ok = 1'b1;
		rsp.cell_value = 1'b0;
		case (req.cmd)
			CMD_STEP: begin
				advance_generation();
			end
			CMD_CLEAR: begin
				for (int y = 0; y < ROWS; y++) shadow_board[y] = '0;
			end
			default: begin
				w = active_width();
				h = active_height();
				c = req.col;
				r = req.row;
				if (shadow_wrap) begin
					c = c % w;
					r = r % h;
				end
				if (c >= w || r >= h) begin
					rsp.ok = 1'b0;
				end else begin
					if (req.cmd == CMD_TOGGLE) shadow_board[r][c] = ~shadow_board[r][c];
					rsp.cell_value = shadow_board[r][c];
				end
			end
		endcase
		return rsp;
	endfunction

	// Drop start for a random idle burst, now and then.
	task automatic maybe_idle();
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Send one command and queue its prediction once the transaction is accepted.
	// Start stays high afterwards; the next command or a wait drops it.
	task automatic send_command(cmd_e cmd, logic [5:0] col, logic [5:0] row);
		req_t req;
		req.cmd = cmd;
		req.col = col;
		req.row = row;
		maybe_idle();
		start <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_rsp_q.push_back(predict_response(req));
	endtask

	// Wait until every response has come, then let the block settle.
	task automatic drain_responses();
		start <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register; only called while the block is idle. The caller drops valid.
	task automatic write_register(logic [1:0] index, logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (index)
			CFG_BOARD_WIDTH: shadow_width = data;
			CFG_BOARD_HEIGHT: shadow_height = data;
			CFG_WRAP_EDGES: shadow_wrap = data[0];
			default: ;
		endcase
	endtask

	task automatic set_board(logic [6:0] w, logic [6:0] h, logic wrap);
		drain_responses();
		write_register(CFG_BOARD_WIDTH, w);
		write_register(CFG_BOARD_HEIGHT, h);
		write_register(CFG_WRAP_EDGES, {6'd0, wrap});
		cfg_valid <= 1'b0;
	endtask

	function automatic cmd_e pick_command();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return CMD_TOGGLE;
		if (p < 60) return CMD_STEP;
		if (p < 63) return CMD_CLEAR;
		return CMD_READ;
	endfunction

	// Directed: field extremes, every command, edge and out-of-range cells, glider.
	task automatic test_directed();
		send_command(CMD_READ, 6'd0, 6'd0);
		send_command(CMD_TOGGLE, 6'd0, 6'd0);
		send_command(CMD_TOGGLE, 6'd63, 6'd63);
		send_command(CMD_TOGGLE, 6'd63, 6'd0);
		send_command(CMD_TOGGLE, 6'd0, 6'd63);
		send_command(CMD_READ, 6'd63, 6'd63);
		// glider in the corner
		send_command(CMD_TOGGLE, 6'd2, 6'd1);
		send_command(CMD_TOGGLE, 6'd3, 6'd2);
		send_command(CMD_TOGGLE, 6'd1, 6'd3);
		send_command(CMD_TOGGLE, 6'd2, 6'd3);
		send_command(CMD_TOGGLE, 6'd3, 6'd3);
		send_command(CMD_STEP, 6'd0, 6'd0);
		send_command(CMD_STEP, 6'd42, 6'd21);
		send_command(CMD_READ, 6'd3, 6'd3);
		send_command(CMD_CLEAR, 6'd63, 6'd63);
		send_command(CMD_READ, 6'd2, 6'd1);
		// small board without wrap: coordinates off the edge give ok low
		set_board(7'd5, 7'd4, 1'b0);
		send_command(CMD_TOGGLE, 6'd5, 6'd0);
		send_command(CMD_READ, 6'd0, 6'd4);
		send_command(CMD_TOGGLE, 6'd4, 6'd3);
		send_command(CMD_STEP, 6'd0, 6'd0);
		send_command(CMD_READ, 6'd4, 6'd3);
	endtask

	// Wrap mode on tiny and degenerate boards, including zero and oversized registers.
	task automatic test_wrap_extremes();
		set_board(7'd1, 7'd1, 1'b1);
		send_command(CMD_TOGGLE, 6'd63, 6'd63);
		send_command(CMD_STEP, 6'd0, 6'd0);
		send_command(CMD_READ, 6'd0, 6'd0);
		set_board(7'd0, 7'd2, 1'b1);
		send_command(CMD_TOGGLE, 6'd9, 6'd1);
		send_command(CMD_STEP, 6'd0, 6'd0);
		send_command(CMD_READ, 6'd0, 6'd3);
		set_board(7'd127, 7'd127, 1'b1);
		send_command(CMD_TOGGLE, 6'd63, 6'd0);
		send_command(CMD_TOGGLE, 6'd0, 6'd0);
		send_command(CMD_TOGGLE, 6'd1, 6'd0);
		send_command(CMD_STEP, 6'd0, 6'd0);
		send_command(CMD_READ, 6'd0, 6'd63);
	endtask

	// Random commands on one board setting; toggles cluster so steps have live patterns.
	task automatic run_random_phase(int count, logic [6:0] w, logic [6:0] h, logic wrap);
		cmd_e cmd;
		int span;
		set_board(w, h, wrap);
		span = (w > 2 && w < 64) ? w + 1 : 63;
		for (int i = 0; i < count; i++) begin
			cmd = pick_command();
			if ($urandom_range(0, 4) == 0)
				send_command(cmd, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			else
				send_command(cmd, 6'($urandom_range(0, span)),
					6'($urandom_range(0, span)));
		end
	endtask

	// Let the queue empty before sending more.
	task automatic test_sender_pause();
		send_command(CMD_TOGGLE, 6'd1, 6'd1);
		start <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		send_command(CMD_READ, 6'd1, 6'd1);
	endtask

	// Compare each response against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: unexpected response ok=%0b cell_value=%0b",
					$time, response.ok, response.cell_value);
				error_count++;
			end else begin
				want = expected_rsp_q.pop_front();
				if (response.ok !== want.ok) begin
					$display("%0t: ok expected %0b actual %0b", $time, want.ok, response.ok);
					error_count++;
				end
				if (response.cell_value !== want.cell_value) begin
					$display("%0t: cell_value expected %0b actual %0b",
						$time, want.cell_value, response.cell_value);
					error_count++;
				end
			end
		end
	end

	// Watchdog: count cycles with no accepted transaction and no response.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BOARD_WIDTH;
		cfg_data = '0;
		error_count = 0;
		idle_cycles = 0;
		allow_gaps = 1'b1;
		shadow_width = 7'd64;
		shadow_height = 7'd64;
		shadow_wrap = 1'b0;
		for (int y = 0; y < ROWS; y++) shadow_board[y] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_wrap_extremes();
		test_sender_pause();
		run_random_phase(60, 7'd8, 7'd8, 1'b1);
		run_random_phase(60, 7'd10, 7'd6, 1'b0);
		run_random_phase(50, 7'd3, 7'd3, 1'b1);
		run_random_phase(40, 7'd2, 7'd1, 1'b1);
		run_random_phase(60, 7'd64, 7'd64, 1'b0);
		run_random_phase(40, 7'd64, 7'd64, 1'b1);
		// last stretch runs back to back
		allow_gaps = 1'b0;
		run_random_phase(60, 7'd16, 7'd12, 1'b1);
		drain_responses();

		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/lca_pkg.sv
hw/rtl/lca_row_cell.sv
hw/rtl/lca_gen_row.sv
hw/rtl/life_cellular_automaton.sv
verif/life_cellular_automaton_tb.sv
